// File: rtl/tsbg_pkg.sv
package tsbg_pkg;

  localparam int PAD_WIDTH_DEF = 916;
  localparam int SEGMENTS_DEF  = 6;

  // configuration port
  localparam int CFG_W     = 15;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_TRAVEL_PX       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_SEMITONES = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SNAP_BAND       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_JUMP_LIMIT      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_FLOOR      = 3'd4;

  // event kinds on the input channel
  localparam logic [1:0] REQ_PRESS   = 2'd0;
  localparam logic [1:0] REQ_DRAG    = 2'd1;
  localparam logic [1:0] REQ_RELEASE = 2'd2;

  // serial divider: |dy| (15 bit) * 16 * range (5 bit) over travel (11 bit)
  localparam int DVD_W = 24;
  localparam int DVS_W = 11;
  localparam int DIV_CNT_W = $clog2(DVD_W);

  typedef struct packed {
    logic [10:0] travel_px;
    logic [4:0]  range_semitones;
    logic [12:0] snap_band;
    logic [14:0] jump_limit;
    logic [14:0] step_floor;
  } cfg_t;

  typedef enum logic [1:0] {
    OP_PRESS,
    OP_DRAG,
    OP_RELEASE,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t                op;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic               hold_on;
  } item_t;

endpackage

// File: rtl/tsbg_if.sv
interface tsbg_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic               hold_on;

  modport source (output valid, req_type, pos_x, pos_y, hold_on, input ready);
  modport sink   (input valid, req_type, pos_x, pos_y, hold_on, output ready);
endinterface

interface tsbg_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         segment;
  logic signed [13:0] bend;
  logic               snapped;
  logic               touching;

  modport source (output valid, segment, bend, snapped, touching, input ready);
  modport sink   (input valid, segment, bend, snapped, touching, output ready);
endinterface

// File: rtl/tsbg_front.sv
module tsbg_front #(
  parameter int PAD_WIDTH = tsbg_pkg::PAD_WIDTH_DEF,
  parameter int SEGMENTS  = tsbg_pkg::SEGMENTS_DEF,
  parameter int SEG_W     = $clog2(SEGMENTS + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  tsbg_in_if.sink           in_chan,
  output logic              q_valid,
  output tsbg_pkg::item_t   q_item,
  output logic [SEG_W-1:0]  q_seg,
  input  logic              q_pop
);

  localparam logic [SEG_W-1:0] SEG_NONE = SEG_W'(SEGMENTS);

  tsbg_pkg::item_t    q_item_r [2];
  logic [SEG_W-1:0]   q_seg_r  [2];
  logic [1:0]         cnt_r, cnt_nxt;
  logic               wp_r, rp_r;
  logic               push;

  tsbg_pkg::item_t    cls_item;
  logic [SEG_W-1:0]   cls_seg;
  logic               x_neg_ok;
  logic               off_strip;
  logic [10:0]        xpix;
  logic [SEGMENTS-1:0] below;

  // integer pixel, truncated toward zero; -15..-1 in Q.4 still lands on pixel 0
  always_comb begin
    x_neg_ok  = (in_chan.pos_x[15:4] == 12'hFFF) && (in_chan.pos_x[3:0] != 4'd0);
    xpix      = x_neg_ok ? 11'd0 : in_chan.pos_x[14:4];
    off_strip = (in_chan.pos_x[15] && !x_neg_ok) || ({1'b0, xpix} >= 12'(PAD_WIDTH));
  end

  for (genvar g = 0; g < SEGMENTS; g++) begin : g_bound
    localparam int BOUND = (g + 1) * PAD_WIDTH / SEGMENTS;
    assign below[g] = {1'b0, xpix} < 12'(BOUND);
  end

  always_comb begin
    cls_seg = SEG_W'(SEGMENTS - 1);
    for (int i = SEGMENTS - 1; i >= 0; i--) begin
      if (below[i]) cls_seg = SEG_W'(i);
    end
    if (off_strip) cls_seg = SEG_NONE;
  end

  always_comb begin
    cls_item.pos_x   = in_chan.pos_x;
    cls_item.pos_y   = in_chan.pos_y;
    cls_item.hold_on = in_chan.hold_on;
    unique case (in_chan.req_type)
      tsbg_pkg::REQ_PRESS:   cls_item.op = tsbg_pkg::OP_PRESS;
      tsbg_pkg::REQ_DRAG:    cls_item.op = tsbg_pkg::OP_DRAG;
      tsbg_pkg::REQ_RELEASE: cls_item.op = tsbg_pkg::OP_RELEASE;
      default:               cls_item.op = tsbg_pkg::OP_NOP;
    endcase
  end

  assign in_chan.ready = (cnt_r != 2'd2);
  assign push          = in_chan.valid && in_chan.ready;
  assign q_valid       = (cnt_r != 2'd0);
  assign q_item        = q_item_r[rp_r];
  assign q_seg         = q_seg_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !(q_pop && q_valid)) cnt_nxt = cnt_r + 2'd1;
    else if (!push && q_pop && q_valid) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= !wp_r;
      if (q_pop && q_valid) rp_r <= !rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_item_r[wp_r] <= cls_item;
      q_seg_r[wp_r]  <= cls_seg;
    end
  end

endmodule

// File: rtl/tsbg_div.sv
module tsbg_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [tsbg_pkg::DVD_W-1:0]     dividend,
  input  logic [tsbg_pkg::DVS_W-1:0]     divisor,
  output logic                           done,
  output logic [tsbg_pkg::DVD_W-1:0]     quotient
);

  localparam int DVD_W = tsbg_pkg::DVD_W;
  localparam int DVS_W = tsbg_pkg::DVS_W;
  localparam int CNT_W = tsbg_pkg::DIV_CNT_W;

  logic [DVD_W-1:0] quo_r;
  logic [DVS_W-1:0] rem_r, dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [DVS_W:0]   trial;
  logic             ge;
  logic [DVS_W:0]   diff;

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial = {rem_r, quo_r[DVD_W-1]};
    ge    = trial >= {1'b0, dvs_r};
    diff  = trial - {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DVD_W-2:0], ge};
      rem_r <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: rtl/tsbg_back.sv
module tsbg_back #(
  parameter int SEGMENTS = tsbg_pkg::SEGMENTS_DEF,
  parameter int SEG_W    = $clog2(SEGMENTS + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  tsbg_pkg::cfg_t    cfg,
  input  logic              q_valid,
  input  tsbg_pkg::item_t   q_item,
  input  logic [SEG_W-1:0]  q_seg,
  output logic              q_pop,
  tsbg_out_if.source        out_chan
);

  localparam logic [SEG_W-1:0] SEG_NONE = SEG_W'(SEGMENTS);
  localparam int DVD_W = tsbg_pkg::DVD_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_DIV,
    S_SETTLE,
    S_DONE
  } state_t;

  state_t             state_r, state_nxt;
  tsbg_pkg::item_t    item_r, item_nxt;
  logic [SEG_W-1:0]   iseg_r, iseg_nxt;
  logic signed [15:0] anchor_x_r, anchor_x_nxt;
  logic signed [15:0] anchor_y_r, anchor_y_nxt;
  logic [SEG_W-1:0]   seg_sel_r, seg_sel_nxt;
  logic signed [13:0] bend_r, bend_nxt;
  logic               snap_r, snap_nxt;
  logic               down_r, down_nxt;
  logic               neg_r, neg_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [2:0]         out_seg_r, out_seg_nxt;
  logic signed [13:0] out_bend_r, out_bend_nxt;
  logic               out_snap_r, out_snap_nxt;
  logic               out_touch_r, out_touch_nxt;

  logic signed [16:0] dx, dy;
  logic [16:0]        adx, ady;
  logic               jump;
  logic [DVD_W-1:0]   dvd;
  logic               div_start;
  logic               div_done;
  logic [DVD_W-1:0]   div_quo;
  logic signed [25:0] delta, sum, lim, snapb, clamped;
  logic [3:0]         seg_ext;

  tsbg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dvd),
    .divisor  (cfg.travel_px),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    dx   = $signed({item_r.pos_x[15], item_r.pos_x}) - $signed({anchor_x_r[15], anchor_x_r});
    dy   = $signed({item_r.pos_y[15], item_r.pos_y}) - $signed({anchor_y_r[15], anchor_y_r});
    adx  = dx[16] ? 17'(-dx) : 17'(dx);
    ady  = dy[16] ? 17'(-dy) : 17'(dy);
    jump = (adx > {2'b00, cfg.jump_limit}) || (ady > {2'b00, cfg.jump_limit});
    // |dy| fits 15 bits once it is inside the jump limit
    dvd  = {5'd0, ady[14:0], 4'd0} * {19'd0, cfg.range_semitones};
  end

  always_comb begin
    delta   = neg_r ? -$signed({2'b00, div_quo}) : $signed({2'b00, div_quo});
    sum     = $signed({{12{bend_r[13]}}, bend_r}) + delta;
    lim     = $signed({13'd0, cfg.range_semitones, 8'd0});
    snapb   = $signed({13'd0, cfg.snap_band});
    clamped = sum;
    if (sum > lim) clamped = lim;
    if (sum < -lim) clamped = -lim;
  end

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    iseg_nxt      = iseg_r;
    anchor_x_nxt  = anchor_x_r;
    anchor_y_nxt  = anchor_y_r;
    seg_sel_nxt   = seg_sel_r;
    bend_nxt      = bend_r;
    snap_nxt      = snap_r;
    down_nxt      = down_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_seg_nxt   = out_seg_r;
    out_bend_nxt  = out_bend_r;
    out_snap_nxt  = out_snap_r;
    out_touch_nxt = out_touch_r;
    q_pop         = 1'b0;
    div_start     = 1'b0;
    seg_ext       = 4'(seg_sel_r);

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          item_nxt  = q_item;
          iseg_nxt  = q_seg;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        state_nxt = S_DONE;
        case (item_r.op)
          tsbg_pkg::OP_PRESS: begin
            anchor_x_nxt = item_r.pos_x;
            anchor_y_nxt = item_r.pos_y;
            seg_sel_nxt  = iseg_r;
            // hold keeps an existing segment's bend going
            if (!(item_r.hold_on && seg_sel_r != SEG_NONE)) begin
              bend_nxt = '0;
              snap_nxt = 1'b1;
            end
            down_nxt = 1'b1;
          end
          tsbg_pkg::OP_DRAG: begin
            if (cfg.travel_px != '0) begin
              if (jump) begin
                anchor_x_nxt = item_r.pos_x;
                anchor_y_nxt = item_r.pos_y;
              end else if (adx > ady) begin
                if (adx >= {2'b00, cfg.step_floor}) begin
                  if (iseg_r != SEG_NONE) seg_sel_nxt = iseg_r;
                  anchor_x_nxt = item_r.pos_x;
                  anchor_y_nxt = item_r.pos_y;
                end
              end else if (ady != '0) begin
                // finger moving down bends downward
                neg_nxt      = !dy[16];
                div_start    = 1'b1;
                anchor_x_nxt = item_r.pos_x;
                anchor_y_nxt = item_r.pos_y;
                state_nxt    = S_DIV;
              end
            end
          end
          tsbg_pkg::OP_RELEASE: begin
            down_nxt = 1'b0;
            if (!item_r.hold_on) begin
              seg_sel_nxt = SEG_NONE;
              bend_nxt    = '0;
              snap_nxt    = 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
      S_DIV: begin
        if (div_done) state_nxt = S_SETTLE;
      end
      S_SETTLE: begin
        if (clamped > -snapb && clamped < snapb) begin
          snap_nxt = 1'b1;
          bend_nxt = '0;
        end else begin
          snap_nxt = 1'b0;
          bend_nxt = clamped[13:0];
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_seg_nxt   = seg_ext[2:0];
          out_bend_nxt  = bend_r;
          out_snap_nxt  = snap_r;
          out_touch_nxt = down_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      anchor_x_r  <= '0;
      anchor_y_r  <= '0;
      seg_sel_r   <= SEG_NONE;
      bend_r      <= '0;
      snap_r      <= 1'b0;
      down_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      anchor_x_r  <= anchor_x_nxt;
      anchor_y_r  <= anchor_y_nxt;
      seg_sel_r   <= seg_sel_nxt;
      bend_r      <= bend_nxt;
      snap_r      <= snap_nxt;
      down_r      <= down_nxt;
      out_valid_r <= out_valid_nxt;
    end
    item_r      <= item_nxt;
    iseg_r      <= iseg_nxt;
    neg_r       <= neg_nxt;
    out_seg_r   <= out_seg_nxt;
    out_bend_r  <= out_bend_nxt;
    out_snap_r  <= out_snap_nxt;
    out_touch_r <= out_touch_nxt;
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.segment  = out_seg_r;
  assign out_chan.bend     = out_bend_r;
  assign out_chan.snapped  = out_snap_r;
  assign out_chan.touching = out_touch_r;

endmodule

// File: rtl/touch_strip_bend_gesture.sv
// Touch strip bend gesture tracker. Press, drag and release events enter on
// in_chan and each one gives exactly one result on out_chan: the selected
// segment (SEGMENTS means none), the bend in Q.8 semitones, the snap flag and
// the touching flag as they stand after that event. A two-entry queue sits
// behind the input, so up to two events are taken while a result waits. A
// vertical drag waits on the 24-step bit-serial divide by travel_px, which a
// press, release, jump or horizontal drag skips. The user must write the
// configuration registers through cfg_we/cfg_index/cfg_wdata only while no
// event is in flight; the block does not enforce this. They reset to travel
// 37, range 12, snap band 128, jump limit 1024 and step floor 64.
module touch_strip_bend_gesture #(
  parameter int PAD_WIDTH = tsbg_pkg::PAD_WIDTH_DEF,
  parameter int SEGMENTS  = tsbg_pkg::SEGMENTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  tsbg_in_if.sink                         in_chan,
  tsbg_out_if.source                      out_chan,
  input  logic                            cfg_we,
  input  logic [tsbg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tsbg_pkg::CFG_W-1:0]      cfg_wdata
);

  localparam int SEG_W = $clog2(SEGMENTS + 1);

  tsbg_pkg::cfg_t     cfg_r, cfg_nxt;
  logic               q_valid;
  tsbg_pkg::item_t    q_item;
  logic [SEG_W-1:0]   q_seg;
  logic               q_pop;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        tsbg_pkg::CFG_TRAVEL_PX:       cfg_nxt.travel_px       = cfg_wdata[10:0];
        tsbg_pkg::CFG_RANGE_SEMITONES: cfg_nxt.range_semitones = cfg_wdata[4:0];
        tsbg_pkg::CFG_SNAP_BAND:       cfg_nxt.snap_band       = cfg_wdata[12:0];
        tsbg_pkg::CFG_JUMP_LIMIT:      cfg_nxt.jump_limit      = cfg_wdata[14:0];
        tsbg_pkg::CFG_STEP_FLOOR:      cfg_nxt.step_floor      = cfg_wdata[14:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.travel_px       <= 11'd37;
      cfg_r.range_semitones <= 5'd12;
      cfg_r.snap_band       <= 13'd128;
      cfg_r.jump_limit      <= 15'd1024;
      cfg_r.step_floor      <= 15'd64;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  tsbg_front #(
    .PAD_WIDTH (PAD_WIDTH),
    .SEGMENTS  (SEGMENTS),
    .SEG_W     (SEG_W)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_seg   (q_seg),
    .q_pop   (q_pop)
  );

  tsbg_back #(
    .SEGMENTS (SEGMENTS),
    .SEG_W    (SEG_W)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_seg    (q_seg),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

endmodule

// File: rtl/tsbg_chk.sv
module tsbg_chk #(
  parameter int SEGMENTS = tsbg_pkg::SEGMENTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [2:0]         out_segment,
  input  logic signed [13:0] out_bend,
  input  logic               out_snapped,
  input  logic               out_touching
);

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_segment) && $stable(out_bend)
      && $stable(out_snapped) && $stable(out_touching))
    else $error("stalled result changed");

  a_snap_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_snapped |-> out_bend == 14'sd0)
    else $error("snapped result with nonzero bend");

  // range register is at most 31 semitones
  a_bend_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_bend >= -14'sd7936 && out_bend <= 14'sd7936)
    else $error("bend beyond largest clamp");

  a_seg_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> SEGMENTS > 7 || out_segment <= 3'(SEGMENTS))
    else $error("segment code out of range");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind touch_strip_bend_gesture tsbg_chk #(.SEGMENTS(SEGMENTS)) u_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .out_segment  (out_chan.segment),
  .out_bend     (out_chan.bend),
  .out_snapped  (out_chan.snapped),
  .out_touching (out_chan.touching)
);
